### hdl/n_queens_backtrack_solver_core_assert.svh
// ----------------------------------------------------------------------------
// n-queens solver assertion macros
// shared same-cycle implication and next-cycle checks for the solver core
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_BACKTRACK_SOLVER_CORE_ASSERT_SVH
`define N_QUEENS_BACKTRACK_SOLVER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NQBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define NQBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nqbs_pkg.sv
// ----------------------------------------------------------------------------
// nqbs_pkg
// types and constants shared by the n-queens backtracking solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nqbs_pkg;

  localparam int MAX_SIDE_DEF = 8;
  localparam int MAX_RESULTS  = 8;

  typedef struct packed {
    logic [3:0] board_size;
    logic [3:0] queens_to_place;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] row_index;
    logic [7:0] row_mask;
    logic       last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FAIL
  } state_t;

endpackage

### hdl/nqbs_cell_check.sv
// ----------------------------------------------------------------------------
// nqbs_cell_check
// shared attack check: tests one cell against the row, column and diagonal
// occupancy masks and gives the diagonal indices of that cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqbs_cell_check #(
  parameter int MAX_SIDE = nqbs_pkg::MAX_SIDE_DEF
) (
  row,
  col,
  row_used,
  col_used,
  d1_used,
  d2_used,
  safe,
  d1_idx,
  d2_idx
);

  localparam int IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DN  = 2 * MAX_SIDE - 1;
  localparam int DIW = (DN > 1) ? $clog2(DN) : 1;

  input  logic [IW-1:0]       row;
  input  logic [IW-1:0]       col;
  input  logic [MAX_SIDE-1:0] row_used;
  input  logic [MAX_SIDE-1:0] col_used;
  input  logic [DN-1:0]       d1_used;
  input  logic [DN-1:0]       d2_used;
  output logic                safe;
  output logic [DIW-1:0]      d1_idx;
  output logic [DIW-1:0]      d2_idx;

  // anti-diagonal is row+col, main diagonal is row-col offset to stay positive
  assign d1_idx = DIW'(row) + DIW'(col);
  assign d2_idx = DIW'(row) + DIW'(MAX_SIDE - 1) - DIW'(col);

  assign safe = !row_used[row] && !col_used[col] && !d1_used[d1_idx] && !d2_used[d2_idx];

endmodule

### hdl/n_queens_backtrack_solver_core.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_core
// depth-first n-queens search with a single shared cell check unit
// ----------------------------------------------------------------------------
// A request gives a board size (saturated to MAX_SIDE) and a queen count. The
// core scans cells in row-major order, one cell per cycle through one shared
// attack check, places a queen on the first safe cell and descends; an
// exhausted scan pops the last queen and resumes after it. After a request
// is accepted the core examines cells, backtracks and detects completion, then
// issues its result words (min(side, 8) words on success, one word on failure)
// while the output is not stalled. The count of examined cells depends on the
// data and grows roughly exponentially with board size. The request side
// stalls for the whole run; the last result word may still be waiting while
// the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module n_queens_backtrack_solver_core #(
  parameter int MAX_SIDE = nqbs_pkg::MAX_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  nqbs_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output nqbs_pkg::rsp_t  rsp
);

`include "n_queens_backtrack_solver_core_assert.svh"

  localparam int IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int DN  = 2 * MAX_SIDE - 1;
  localparam int DIW = (DN > 1) ? $clog2(DN) : 1;

  nqbs_pkg::state_t state, state_next;

  logic [SW-1:0]       side;
  logic [3:0]          queens;
  logic [SW-1:0]       depth;
  logic [SW-1:0]       scan_row;
  logic [IW-1:0]       scan_col;
  logic [SW-1:0]       ek;
  logic [SW-1:0]       nres;
  logic [MAX_SIDE-1:0] row_used;
  logic [MAX_SIDE-1:0] col_used;
  logic [DN-1:0]       d1_used;
  logic [DN-1:0]       d2_used;
  logic [MAX_SIDE-1:0] occ     [MAX_SIDE];
  logic [IW-1:0]       stk_row [MAX_SIDE];
  logic [IW-1:0]       stk_col [MAX_SIDE];

  logic                accept;
  logic [SW-1:0]       side_sat;
  logic [SW-1:0]       nres_sat;
  logic                start_fail;
  logic                at_goal;
  logic                scan_done;
  logic [SW-1:0]       depth_m1;
  logic [IW-1:0]       top;
  logic [IW-1:0]       chk_row;
  logic [IW-1:0]       chk_col;
  logic                safe;
  logic [DIW-1:0]      d1_idx;
  logic [DIW-1:0]      d2_idx;
  logic [SW-1:0]       adv_row;
  logic [IW-1:0]       adv_col;
  logic                do_place;
  logic                do_pop;
  logic                do_adv;
  logic                emit_step;
  logic                emit_last;
  logic                rsp_free;
  logic                rsp_load;
  nqbs_pkg::rsp_t      rsp_data;
  logic [MAX_SIDE+7:0] mask_pad;
  logic [SW+2:0]       idx_pad;

  assign req_stall = (state != nqbs_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    if (int'(req.board_size) > MAX_SIDE) begin
      side_sat = SW'(MAX_SIDE);
    end else begin
      side_sat = SW'(req.board_size);
    end
    if (int'(side_sat) > nqbs_pkg::MAX_RESULTS) begin
      nres_sat = SW'(nqbs_pkg::MAX_RESULTS);
    end else begin
      nres_sat = side_sat;
    end
  end

  // an empty board fails at once, and more queens than rows can never fit
  assign start_fail = (side_sat == '0) || (int'(req.queens_to_place) > int'(side_sat));

  assign at_goal   = (int'(depth) == int'(queens));
  assign scan_done = (scan_row == side);
  assign depth_m1  = depth - SW'(1);
  assign top       = depth_m1[IW-1:0];

  // after an exhausted scan the check unit looks at the popped cell instead
  assign chk_row = scan_done ? stk_row[top] : scan_row[IW-1:0];
  assign chk_col = scan_done ? stk_col[top] : scan_col;

  nqbs_cell_check #(
    .MAX_SIDE (MAX_SIDE)
  ) u_check (
    .row      (chk_row),
    .col      (chk_col),
    .row_used (row_used),
    .col_used (col_used),
    .d1_used  (d1_used),
    .d2_used  (d2_used),
    .safe     (safe),
    .d1_idx   (d1_idx),
    .d2_idx   (d2_idx)
  );

  always_comb begin
    if ((SW'(chk_col) + SW'(1)) == side) begin
      adv_row = SW'(chk_row) + SW'(1);
      adv_col = '0;
    end else begin
      adv_row = SW'(chk_row);
      adv_col = chk_col + IW'(1);
    end
  end

  assign mask_pad  = {8'b0, occ[ek[IW-1:0]]};
  assign idx_pad   = {3'b0, ek};
  assign emit_last = ((int'(ek) + 1) == int'(nres));

  always_comb begin
    state_next = state;
    do_place   = 1'b0;
    do_pop     = 1'b0;
    do_adv     = 1'b0;
    emit_step  = 1'b0;
    rsp_load   = 1'b0;
    rsp_data   = '0;
    case (state)
      nqbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = start_fail ? nqbs_pkg::ST_FAIL : nqbs_pkg::ST_SCAN;
        end
      end
      nqbs_pkg::ST_SCAN: begin
        if (at_goal) begin
          state_next = nqbs_pkg::ST_EMIT;
        end else if (scan_done) begin
          if (depth == '0) begin
            state_next = nqbs_pkg::ST_FAIL;
          end else begin
            do_pop = 1'b1;
            do_adv = 1'b1;
          end
        end else begin
          do_place = safe;
          do_adv   = 1'b1;
        end
      end
      nqbs_pkg::ST_EMIT: begin
        rsp_data.found     = 1'b1;
        rsp_data.row_index = idx_pad[2:0];
        rsp_data.row_mask  = mask_pad[7:0];
        rsp_data.last      = emit_last;
        if (rsp_free) begin
          rsp_load  = 1'b1;
          emit_step = 1'b1;
          if (emit_last) begin
            state_next = nqbs_pkg::ST_IDLE;
          end
        end
      end
      nqbs_pkg::ST_FAIL: begin
        rsp_data.last = 1'b1;
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = nqbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nqbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nqbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      scan_row <= '0;
      scan_col <= '0;
      row_used <= '0;
      col_used <= '0;
      d1_used  <= '0;
      d2_used  <= '0;
    end else if (accept) begin
      depth    <= '0;
      scan_row <= '0;
      scan_col <= '0;
      row_used <= '0;
      col_used <= '0;
      d1_used  <= '0;
      d2_used  <= '0;
    end else begin
      if (do_adv) begin
        scan_row <= adv_row;
        scan_col <= adv_col;
      end
      if (do_place) begin
        depth             <= depth + SW'(1);
        row_used[chk_row] <= 1'b1;
        col_used[chk_col] <= 1'b1;
        d1_used[d1_idx]   <= 1'b1;
        d2_used[d2_idx]   <= 1'b1;
      end else if (do_pop) begin
        depth             <= depth_m1;
        row_used[chk_row] <= 1'b0;
        col_used[chk_col] <= 1'b0;
        d1_used[d1_idx]   <= 1'b0;
        d2_used[d2_idx]   <= 1'b0;
      end
    end
  end

  // board, stack and request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      side   <= side_sat;
      queens <= req.queens_to_place;
      nres   <= nres_sat;
      ek     <= '0;
      for (int i = 0; i < MAX_SIDE; i++) begin
        occ[i] <= '0;
      end
    end else begin
      if (do_place) begin
        occ[chk_row][chk_col] <= 1'b1;
        stk_row[depth[IW-1:0]] <= chk_row;
        stk_col[depth[IW-1:0]] <= chk_col;
      end else if (do_pop) begin
        occ[chk_row][chk_col] <= 1'b0;
      end
      if (emit_step) begin
        ek <= ek + SW'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_data;
    end
  end

  `NQBS_ASSERT_IMP(a_depth_bound, clk, rst, state == nqbs_pkg::ST_SCAN,
                   int'(depth) <= int'(queens), "search depth above queen count")
  `NQBS_ASSERT_IMP(a_col_count, clk, rst, state == nqbs_pkg::ST_SCAN,
                   $countones(col_used) == int'(depth), "column mask out of step with depth")
  `NQBS_ASSERT_IMP(a_row_count, clk, rst, state == nqbs_pkg::ST_SCAN,
                   $countones(row_used) == $countones(d1_used), "row and diagonal masks differ")
  `NQBS_ASSERT_IMP(a_fail_word, clk, rst, rsp_valid && !rsp.found,
                   rsp.last && (rsp.row_mask == 8'd0), "failure word not a lone empty word")
  `NQBS_ASSERT_NXT(a_fail_done, clk, rst, (state == nqbs_pkg::ST_FAIL) && rsp_free,
                   rsp_valid && rsp.last && (state == nqbs_pkg::ST_IDLE),
                   "failure word not issued")

endmodule

### verif/n_queens_backtrack_solver_core_tb.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_core_tb
// self-checking bench for the n-queens backtracking solver core
// ----------------------------------------------------------------------------
// Requests are fed from a queue through a valid/stall driver. Each accepted
// request is solved again by a local depth-first search. The expected row
// words are queued and compared field by field against every result word
// taken from the core. Both sides idle at random, except for one quiet
// stretch. A watchdog scales its limit with the search effort of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module n_queens_backtrack_solver_core_tb;

  localparam int SIDE_CAP  = nqbs_pkg::MAX_SIDE_DEF;
  localparam int END_WAIT  = 64;
  localparam int IDLE_PCT  = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  nqbs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  nqbs_pkg::rsp_t rsp;

  n_queens_backtrack_solver_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nqbs_pkg::req_t pending_reqs[$];
  nqbs_pkg::rsp_t expected_rows[$];

  // local copy of the search state
  logic [7:0]  board_rows [SIDE_CAP];
  logic [5:0]  queen_cells [SIDE_CAP];
  int unsigned queens_down;
  int unsigned next_cell;

  int errors = 0;
  int n_requests = 0;
  int n_solved = 0;
  int n_unsolved = 0;
  int n_words = 0;
  int n_sent = 0;
  int idle_limit = 20000;
  int stuck_cycles = 0;
  logic req_took = 1'b0;
  logic quiet;

  wire req_fire = req_valid && !req_stall;
  wire rsp_fire = rsp_valid && !rsp_stall;

  // no random idling on either side for a stretch of the random items
  assign quiet = (n_sent >= 30) && (n_sent < 60);

  function automatic bit cell_free(int row, int col, int side);
    int d;
    if (board_rows[row] != 8'd0) return 1'b0;
    for (int r = 0; r < side; r++) begin
      if (board_rows[r] == 8'd0) continue;
      d = (r > row) ? r - row : row - r;
      if (board_rows[r][col]) return 1'b0;
      if (col + d < side && board_rows[r][col + d]) return 1'b0;
      if (d <= col && board_rows[r][col - d]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // depth-first search over cells, resuming after a removed queen;
  // effort counts cells examined plus backtracks
  function automatic bit place_queens(int side, int goal, output int effort);
    int cells;
    int c;
    bit placed;
    cells = side * side;
    effort = 1;
    for (int r = 0; r < SIDE_CAP; r++) board_rows[r] = 8'd0;
    queens_down = 0;
    next_cell = 0;
    if (goal > side) return 1'b0;
    while (1) begin
      if (queens_down == goal) return 1'b1;
      placed = 1'b0;
      while (next_cell < cells) begin
        effort++;
        if (cell_free(next_cell / side, next_cell % side, side)) begin
          board_rows[next_cell / side][next_cell % side] = 1'b1;
          queen_cells[queens_down] = next_cell[5:0];
          queens_down++;
          next_cell++;
          placed = 1'b1;
          break;
        end
        next_cell++;
      end
      if (!placed) begin
        if (queens_down == 0) return 1'b0;
        queens_down--;
        effort++;
        c = queen_cells[queens_down];
        board_rows[c / side][c % side] = 1'b0;
        next_cell = c + 1;
      end
    end
  endfunction

  function automatic int predict_rows(nqbs_pkg::req_t word);
    int side;
    int effort;
    nqbs_pkg::rsp_t row_word;
    side = (word.board_size > SIDE_CAP) ? SIDE_CAP : int'(word.board_size);
    effort = 1;
    if (side == 0 || !place_queens(side, int'(word.queens_to_place), effort)) begin
      row_word = '0;
      row_word.last = 1'b1;
      expected_rows.push_back(row_word);
      n_unsolved++;
    end else begin
      for (int k = 0; k < side; k++) begin
        row_word.found     = 1'b1;
        row_word.row_index = k[2:0];
        row_word.row_mask  = board_rows[k];
        row_word.last      = (k == side - 1);
        expected_rows.push_back(row_word);
      end
      n_solved++;
    end
    return effort;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // monitor: check result words, predict accepted requests
  always @(posedge clk) begin
    nqbs_pkg::rsp_t want;
    int effort;
    req_took <= req_fire && !rst;
    if (!rst && rsp_fire) begin
      n_words++;
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected word", int'(rsp), 0);
      end else begin
        want = expected_rows.pop_front();
        if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
        if (rsp.row_index !== want.row_index)
          report_mismatch("row_index", rsp.row_index, want.row_index);
        if (rsp.row_mask !== want.row_mask)
          report_mismatch("row_mask", rsp.row_mask, want.row_mask);
        if (rsp.last !== want.last) report_mismatch("last", rsp.last, want.last);
      end
    end
    if (!rst && req_fire) begin
      n_requests++;
      effort = predict_rows(req);
      if (4 * effort + 5000 > idle_limit) idle_limit = 4 * effort + 5000;
    end
  end

  // driver: requests and result stall change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      if (!req_valid || req_took) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          n_sent    <= n_sent + 1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= idle_limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_req(int side, int goal);
    nqbs_pkg::req_t word;
    word.board_size      = side[3:0];
    word.queens_to_place = goal[3:0];
    pending_reqs.push_back(word);
  endtask

  initial begin
    int side;
    int pick;
    // zero board, zero queens, tiny boards, full boards up to the largest
    add_req(0, 0);
    add_req(0, 5);
    add_req(0, 15);
    add_req(1, 0);
    add_req(1, 1);
    add_req(1, 2);
    add_req(2, 1);
    add_req(2, 2);
    add_req(3, 2);
    add_req(3, 3);
    add_req(4, 4);
    add_req(5, 5);
    add_req(6, 6);
    add_req(7, 7);
    add_req(8, 8);
    add_req(8, 0);
    add_req(8, 1);
    // oversized boards saturate
    add_req(15, 0);
    add_req(15, 3);
    add_req(12, 5);
    add_req(9, 15);
    // more queens than rows
    add_req(4, 9);
    add_req(5, 10);
    add_req(7, 8);

    for (int i = 0; i < 76; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        side = $urandom_range(7, 1);
        add_req(side, $urandom_range(side, 0));
      end else if (pick < 75) begin
        add_req($urandom_range(15, 7), $urandom_range(5, 0));
      end else if (pick < 90) begin
        side = $urandom_range(7, 0);
        add_req(side, $urandom_range(15, side + 1));
      end else begin
        add_req($urandom_range(15, 0), $urandom_range(3, 0));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (expected_rows.size() > 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d requests: %0d placements found, %0d without placement",
             n_requests, n_solved, n_unsolved);
    $display("checked %0d result words, %0d mismatches", n_words, errors);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
